### hdl/awac_pkg.sv
// Shared types and constants for the ADC window average classifier.
`default_nettype none

package awac_pkg;

  // Configuration port
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;

  typedef logic [CFG_W-1:0]     cfg_data_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_RAIN_WET = 2'd0;
  localparam cfg_idx_t REG_RAIN_DRY = 2'd1;
  localparam cfg_idx_t REG_SOIL_DRY = 2'd2;
  localparam cfg_idx_t REG_SOIL_WET = 2'd3;

  localparam cfg_data_t RAIN_WET_RST = 12'd1500;
  localparam cfg_data_t RAIN_DRY_RST = 12'd3000;
  localparam cfg_data_t SOIL_DRY_RST = 12'd3500;
  localparam cfg_data_t SOIL_WET_RST = 12'd1500;

  // Channel codes
  localparam logic MODE_RAIN = 1'b0;
  localparam logic MODE_SOIL = 1'b1;

  // Rain classes
  localparam int LEVEL_W = 2;
  typedef logic [LEVEL_W-1:0] level_t;
  localparam level_t LEVEL_DRY   = 2'd0;
  localparam level_t LEVEL_LIGHT = 2'd1;
  localparam level_t LEVEL_HEAVY = 2'd2;

  // Result fields
  localparam int WSUM_W = 16;
  typedef logic [WSUM_W-1:0] wsum_t;
  localparam wsum_t WSUM_MAX = 16'hFFFF;

  // Moisture in percent times 256; the divider yields one quotient bit per cycle
  localparam int Q8_W = 15;
  typedef logic [Q8_W-1:0] q8_t;
  localparam q8_t Q8_FULL  = 15'd25600;
  localparam int  QBITS    = Q8_W;
  localparam int  SCALE_W  = 16;
  localparam logic [SCALE_W-1:0] SCALE_X2 = 16'd51200;

endpackage

`default_nettype wire

### hdl/awac_if.sv
// Valid/ready channel interfaces for samples in and classified results out.
`default_nettype none

interface awac_in_if #(
  parameter int SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic                   mode;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, mode, sample, input ready);
  modport sink   (input valid, mode, sample, output ready);
endinterface

interface awac_out_if;
  import awac_pkg::*;

  logic   valid;
  logic   ready;
  logic   channel;
  wsum_t  window_sum;
  level_t rain_level;
  logic   rain_detected;
  q8_t    moisture_pct_q8;

  modport source (output valid, channel, window_sum, rain_level, rain_detected,
                  moisture_pct_q8, input ready);
  modport sink   (input valid, channel, window_sum, rain_level, rain_detected,
                  moisture_pct_q8, output ready);
endinterface

`default_nettype wire

### hdl/awac_ram.sv
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module awac_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hdl/adc_window_average_classifier.sv
// Two-channel moving-average classifier: rain class and soil moisture percent.
// Sequence: a rain item goes through ring update, compare and result load; a soil item through
// update, compare, multiply, 15 divider steps and load; a clamped value skips the divider.
// Flow: one item at a time, soil items through a restoring divider; an item may be
// accepted while the last result waits.
// Reset (synchronous, active low) clears channel state and restores threshold defaults.
`default_nettype none

module adc_window_average_classifier #(
  parameter int WINDOW      = 10,
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  awac_in_if.sink                  in_if,
  awac_out_if.source               out_if,
  input  wire logic                cfg_we,
  input  wire awac_pkg::cfg_idx_t  cfg_index,
  input  wire awac_pkg::cfg_data_t cfg_data
);
  import awac_pkg::*;

  localparam int PW     = $clog2(WINDOW);
  localparam int AW     = PW + 1;
  localparam int DEPTH  = 2 ** AW;
  localparam int SUM_W  = SAMPLE_BITS + PW;
  localparam int LVL_W  = CFG_W + PW;
  localparam int MAG_W  = (SUM_W > LVL_W) ? SUM_W : LVL_W;
  localparam int NUM_W  = MAG_W + 1;
  localparam int N_W    = LVL_W + SCALE_W;
  localparam int REM_W  = N_W - QBITS;
  localparam int CNT_W  = $clog2(QBITS);
  localparam int EXT_W  = (SUM_W > WSUM_W) ? SUM_W : WSUM_W;
  localparam logic [PW-1:0] POS_LAST = PW'(WINDOW - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  // Control state
  logic [2:0]             state_r, state_nxt;
  logic                   primed_r [2], primed_nxt [2];
  logic                   lap_r    [2], lap_nxt    [2];
  logic [PW-1:0]          pos_r    [2], pos_nxt    [2];
  logic [SUM_W-1:0]       sum_r    [2], sum_nxt    [2];
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  cfg_data_t              rain_wet_r, rain_dry_r, soil_dry_r, soil_wet_r;

  // Payload
  logic [SAMPLE_BITS-1:0] fill_r   [2], fill_nxt   [2];
  logic                   mode_r, mode_nxt;
  logic [SAMPLE_BITS-1:0] samp_r, samp_nxt;
  level_t                 level_r, level_nxt;
  q8_t                    moist_r, moist_nxt;
  logic [LVL_W-1:0]       num_r, num_nxt, den_r, den_nxt;
  logic [REM_W-1:0]       rem_r, rem_nxt, dvs_r, dvs_nxt;
  logic [QBITS-1:0]       nbits_r, nbits_nxt;
  logic                   out_ch_r;
  wsum_t                  out_sum_r;
  level_t                 out_level_r;
  q8_t                    out_moist_r;

  // Ring memory, one half per channel
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  awac_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (samp_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Thresholds scaled to window sums
  logic [LVL_W-1:0] rain_wet_w, rain_dry_w, soil_dry_w, soil_wet_w;
  assign rain_wet_w = LVL_W'(rain_wet_r) * LVL_W'(WINDOW);
  assign rain_dry_w = LVL_W'(rain_dry_r) * LVL_W'(WINDOW);
  assign soil_dry_w = LVL_W'(soil_dry_r) * LVL_W'(WINDOW);
  assign soil_wet_w = LVL_W'(soil_wet_r) * LVL_W'(WINDOW);

  logic [SUM_W-1:0]       cur_sum;
  logic [SAMPLE_BITS-1:0] old_samp;
  logic signed [NUM_W-1:0] num_s, den_s, numa_s, dena_s;
  logic [N_W-1:0]         prod;
  logic [REM_W:0]         trial;
  logic                   ge;
  logic [EXT_W-1:0]       sum_ext;
  logic                   out_load;

  assign cur_sum  = sum_r[mode_r];
  assign old_samp = (lap_r[mode_r] && (pos_r[mode_r] != '0)) ? fill_r[mode_r] : ram_rdata;
  assign num_s    = $signed(NUM_W'(soil_dry_w)) - $signed(NUM_W'(cur_sum));
  assign den_s    = $signed(NUM_W'(soil_dry_w)) - $signed(NUM_W'(soil_wet_w));
  assign numa_s   = den_s[NUM_W-1] ? -num_s : num_s;
  assign dena_s   = den_s[NUM_W-1] ? -den_s : den_s;
  assign prod     = N_W'(num_r) * N_W'(SCALE_X2) + N_W'(den_r);
  assign trial    = {rem_r, nbits_r[QBITS-1]};
  assign ge       = trial >= {1'b0, dvs_r};
  assign sum_ext  = EXT_W'(cur_sum);

  assign in_if.ready = (state_r == S_IDLE);
  assign ram_raddr   = {in_if.mode, pos_r[in_if.mode]};
  assign ram_waddr   = {mode_r, pos_r[mode_r]};

  // Sequencer: read ring, update sum, classify or map, divide, deliver
  always_comb begin
    state_nxt  = state_r;
    primed_nxt = primed_r;
    lap_nxt    = lap_r;
    pos_nxt    = pos_r;
    sum_nxt    = sum_r;
    fill_nxt   = fill_r;
    cnt_nxt    = cnt_r;
    mode_nxt   = mode_r;
    samp_nxt   = samp_r;
    level_nxt  = level_r;
    moist_nxt  = moist_r;
    num_nxt    = num_r;
    den_nxt    = den_r;
    rem_nxt    = rem_r;
    dvs_nxt    = dvs_r;
    nbits_nxt  = nbits_r;
    ram_we     = 1'b0;
    out_load   = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          mode_nxt  = in_if.mode;
          samp_nxt  = in_if.sample;
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        ram_we = 1'b1;
        if (!primed_r[mode_r]) begin
          // first beat of the channel stands for the whole window
          sum_nxt[mode_r]    = SUM_W'(samp_r) * SUM_W'(WINDOW);
          pos_nxt[mode_r]    = PW'(1);
          primed_nxt[mode_r] = 1'b1;
          lap_nxt[mode_r]    = 1'b1;
          fill_nxt[mode_r]   = samp_r;
        end else begin
          sum_nxt[mode_r] = cur_sum - SUM_W'(old_samp) + SUM_W'(samp_r);
          if (pos_r[mode_r] == POS_LAST) begin
            pos_nxt[mode_r] = '0;
            lap_nxt[mode_r] = 1'b0;
          end else begin
            pos_nxt[mode_r] = pos_r[mode_r] + PW'(1);
          end
        end
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (mode_r == MODE_RAIN) begin
          moist_nxt = '0;
          if (MAG_W'(cur_sum) <= MAG_W'(rain_wet_w)) begin
            level_nxt = LEVEL_HEAVY;
          end else if (MAG_W'(cur_sum) < MAG_W'(rain_dry_w)) begin
            level_nxt = LEVEL_LIGHT;
          end else begin
            level_nxt = LEVEL_DRY;
          end
          state_nxt = S_DONE;
        end else begin
          level_nxt = LEVEL_DRY;
          if ((den_s == '0) || (numa_s <= 0)) begin
            moist_nxt = '0;
            state_nxt = S_DONE;
          end else if (numa_s >= dena_s) begin
            moist_nxt = Q8_FULL;
            state_nxt = S_DONE;
          end else begin
            num_nxt   = numa_s[LVL_W-1:0];
            den_nxt   = dena_s[LVL_W-1:0];
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        // dividend num*51200 + den, divisor 2*den: rounds halves up
        rem_nxt   = prod[N_W-1:QBITS];
        nbits_nxt = prod[QBITS-1:0];
        dvs_nxt   = {den_r, 1'b0};
        cnt_nxt   = CNT_W'(QBITS - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt   = ge ? REM_W'(trial - {1'b0, dvs_r}) : trial[REM_W-1:0];
        nbits_nxt = nbits_r << 1;
        moist_nxt = {moist_r[QBITS-2:0], ge};
        cnt_nxt   = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold the result until the sink takes the beat
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      primed_r    <= '{default: 1'b0};
      lap_r       <= '{default: 1'b0};
      pos_r       <= '{default: '0};
      sum_r       <= '{default: '0};
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      primed_r    <= primed_nxt;
      lap_r       <= lap_nxt;
      pos_r       <= pos_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Threshold registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rain_wet_r <= RAIN_WET_RST;
      rain_dry_r <= RAIN_DRY_RST;
      soil_dry_r <= SOIL_DRY_RST;
      soil_wet_r <= SOIL_WET_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RAIN_WET: rain_wet_r <= cfg_data;
        REG_RAIN_DRY: rain_dry_r <= cfg_data;
        REG_SOIL_DRY: soil_dry_r <= cfg_data;
        REG_SOIL_WET: soil_wet_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    fill_r  <= fill_nxt;
    mode_r  <= mode_nxt;
    samp_r  <= samp_nxt;
    level_r <= level_nxt;
    moist_r <= moist_nxt;
    num_r   <= num_nxt;
    den_r   <= den_nxt;
    rem_r   <= rem_nxt;
    dvs_r   <= dvs_nxt;
    nbits_r <= nbits_nxt;
    if (out_load) begin
      out_ch_r    <= mode_r;
      out_sum_r   <= (sum_ext > EXT_W'(WSUM_MAX)) ? WSUM_MAX : sum_ext[WSUM_W-1:0];
      out_level_r <= level_r;
      out_moist_r <= moist_r;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.channel         = out_ch_r;
  assign out_if.window_sum      = out_sum_r;
  assign out_if.rain_level      = out_level_r;
  assign out_if.rain_detected   = (out_level_r != LEVEL_DRY);
  assign out_if.moisture_pct_q8 = out_moist_r;

  // Checks
  a_accept_to_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> (state_r == S_SUM))
    else $error("accepted beat did not start a ring update");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < dvs_r))
    else $error("divider remainder not below divisor");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r[0] <= POS_LAST) && (pos_r[1] <= POS_LAST))
    else $error("ring position beyond window");

  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_moist_r <= Q8_FULL) &&
                     ((out_ch_r == MODE_RAIN) || (out_level_r == LEVEL_DRY))))
    else $error("result fields out of range for channel");

endmodule

`default_nettype wire
